>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line blender. Defining
// ASSERT_OFF turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define BLM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define BLM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BLM_ASSERT_IMP(label, clk, rst, ante, cons)

`define BLM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/blm_pkg.sv
// ----------------------------------------------------------------------------
// Line blender package
// Shared types, constants and per-channel blend functions.
// ----------------------------------------------------------------------------
package blm_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam int PIX_W   = 32;
   localparam int RGB_W   = 24;
   localparam int POS_W   = 11;
   localparam int SIZE_W  = 12;
   localparam int CSR_A_W = 4;

   localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd480;

   localparam logic [CSR_A_W-1:0] CSR_EVEN_MODE = 4'd0;
   localparam logic [CSR_A_W-1:0] CSR_ODD_MODE  = 4'd1;
   localparam logic [CSR_A_W-1:0] CSR_WIDTH     = 4'd2;
   localparam logic [CSR_A_W-1:0] CSR_HEIGHT    = 4'd3;

   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_COPY,
      MODE_SMOOTH,
      MODE_UP,
      MODE_DOWN
   } blm_mode_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
      logic             done;
   } blm_rsp_type;

   // Three-row smoothing of one 8-bit channel; the low-bit carry of the
   // upper two rows is part of the rounding.
   function automatic logic [7:0] smooth_chan(logic [7:0] a, logic [7:0] b,
                                              logic [7:0] c);
      logic [8:0] sum;
      logic [8:0] res;
      sum = {2'b00, a[7:1]} + {2'b00, c[7:1]} + {8'b0, a[0] & b[0]};
      res = {1'b0, sum[8:1]} + {2'b00, b[7:1]};
      return res[7:0];
   endfunction

   function automatic logic [RGB_W-1:0] smooth3(logic [RGB_W-1:0] a,
                                                logic [RGB_W-1:0] b,
                                                logic [RGB_W-1:0] c);
      logic [RGB_W-1:0] res;
      for (int i = 0; i < 3; i++) begin
         res[i*8 +: 8] = smooth_chan(a[i*8 +: 8], b[i*8 +: 8], c[i*8 +: 8]);
      end
      return res;
   endfunction

   // floor((p + 3*q) / 4) on each channel.
   function automatic logic [RGB_W-1:0] quarter(logic [RGB_W-1:0] p,
                                                logic [RGB_W-1:0] q);
      logic [RGB_W-1:0] res;
      logic [9:0]       sum;
      for (int i = 0; i < 3; i++) begin
         sum = {2'b00, p[i*8 +: 8]} + {2'b00, q[i*8 +: 8]}
             + {1'b0, q[i*8 +: 8], 1'b0};
         res[i*8 +: 8] = sum[9:2];
      end
      return res;
   endfunction

endpackage

>>> src/blm_line_ram.sv
// ----------------------------------------------------------------------------
// Line buffer memory
// One-read, one-write synchronous memory holding the two previous rows of
// each column. Read data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module blm_line_ram #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 48
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/blm_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small queue taking up to two result beats a cycle and handing out one while out_stall is low.
// Room is judged on the registered fill level only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blm_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push0,
   input  logic                push1,
   input  blm_pkg::blm_rsp_type push0_data,
   input  blm_pkg::blm_rsp_type push1_data,
   output logic                room,
   output logic                out_valid,
   input  logic                out_stall,
   output blm_pkg::blm_rsp_type out_data
);

   import blm_pkg::*;

   localparam int PW   = $clog2(RSP_DEPTH);
   localparam int CNTW = $clog2(RSP_DEPTH + 1);

   blm_rsp_type     mem_ff [RSP_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [1:0]      push_n;
   logic            pop;

   assign push_n    = {1'b0, push0} + {1'b0, push1};
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;
   assign room      = (count_ff <= CNTW'(RSP_DEPTH - 2));
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CNTW'(push_n) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ptr_ff] <= push0_data;
      end
      if (push1) begin
         mem_ff[PW'(wr_ptr_ff + PW'(1))] <= push1_data;
      end
   end

   `BLM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(RSP_DEPTH))
   `BLM_ASSERT_IMP(a_push_order, clock, reset, push1, push0)
   `BLM_ASSERT_IMP(a_push_room, clock, reset, push0, count_ff <= CNTW'(RSP_DEPTH - 2))

endmodule

>>> src/field_bob_line_blender_core.sv
// Path: an accepted pixel is held in the blend stage, then queued for rsp_.
// Throughput: one pixel per cycle while the result queue has room; rows with two
// beats per pixel run at the queue's one beat per cycle while rsp_stall is low.
// One line buffer read and one write per pixel, with a bypass for equal columns.
// Reset: synchronous, clears position, modes and queue and restores the default size;
// line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Field line blender core
// Vertical line blending of field-split frames in raster order, with the two
// previous rows of each column kept in one line buffer memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module field_bob_line_blender_core #(
   parameter int MAX_WIDTH  = blm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = blm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [blm_pkg::PIX_W-1:0]    req_pixel,
   input  logic                         req_odd_frame,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [blm_pkg::PIX_W-1:0]    rsp_out_pixel,
   output logic [blm_pkg::POS_W-1:0]    rsp_out_row,
   output logic [blm_pkg::POS_W-1:0]    rsp_out_col,
   output logic                         rsp_last_of_run,
   output logic                         rsp_frame_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [blm_pkg::CSR_A_W-1:0]  csr_index,
   input  logic [blm_pkg::SIZE_W-1:0]   csr_data
);

   import blm_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int LINE_W = 2 * RGB_W;

   function automatic logic [31:0] size_last(logic [SIZE_W-1:0] v, int unsigned maxv);
      logic [31:0] res;
      if (v == '0) begin
         res = '0;
      end else if (32'(v) > maxv) begin
         res = maxv - 1;
      end else begin
         res = 32'(v) - 32'd1;
      end
      return res;
   endfunction

   // Configuration
   blm_mode_type even_mode_ff, odd_mode_ff;
   logic [CW-1:0] wlast_ff;
   logic [RW-1:0] hlast_ff;
   logic          csr_wr;

   // Position and frame mode
   logic [CW-1:0] col_ff, col_in, c0;
   logic [RW-1:0] row_ff, row_in, r0;
   blm_mode_type  frame_mode_ff, frame_mode_in;
   logic          req_acc;

   // Blend stage
   logic              s1_valid_ff, s1_valid_in, s1_fire;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [CW-1:0]     s1_col_ff;
   logic [RW-1:0]     s1_row_ff;
   blm_mode_type      s1_mode_ff;
   logic              fwd_hit_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] ram_rd_data, line_data, line_wr_data;
   logic [RGB_W-1:0]  pv, pp, rgb;
   logic              row_is_last, col_is_last;

   blm_rsp_type   slot0, slot1;
   logic          v0, v1;
   logic          fifo_room;
   blm_rsp_type   rsp_data;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         even_mode_ff <= MODE_COPY;
         odd_mode_ff  <= MODE_COPY;
         wlast_ff     <= CW'(size_last(WIDTH_RST, MAX_WIDTH));
         hlast_ff     <= RW'(size_last(HEIGHT_RST, MAX_HEIGHT));
      end else if (csr_wr) begin
         case (csr_index)
            CSR_EVEN_MODE: even_mode_ff <= blm_mode_type'(csr_data[1:0]);
            CSR_ODD_MODE:  odd_mode_ff  <= blm_mode_type'(csr_data[1:0]);
            CSR_WIDTH:     wlast_ff     <= CW'(size_last(csr_data, MAX_WIDTH));
            CSR_HEIGHT:    hlast_ff     <= RW'(size_last(csr_data, MAX_HEIGHT));
            default: begin
            end
         endcase
      end
   end

   assign s1_fire   = s1_valid_ff && fifo_room;
   assign req_stall = s1_valid_ff && !fifo_room;
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      c0 = (col_ff > wlast_ff) ? wlast_ff : col_ff;
      r0 = (row_ff > hlast_ff) ? hlast_ff : row_ff;
      frame_mode_in = frame_mode_ff;
      if (col_ff == '0 && row_ff == '0) begin
         frame_mode_in = req_odd_frame ? odd_mode_ff : even_mode_ff;
      end
      if (c0 == wlast_ff) begin
         col_in = '0;
         row_in = (r0 == hlast_ff) ? '0 : RW'(r0 + RW'(1));
      end else begin
         col_in = CW'(c0 + CW'(1));
         row_in = r0;
      end
      s1_valid_in = req_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         frame_mode_ff <= MODE_COPY;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_acc) begin
            col_ff        <= col_in;
            row_ff        <= row_in;
            frame_mode_ff <= frame_mode_in;
            fwd_hit_ff    <= s1_fire && (c0 == s1_col_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pix_ff   <= req_pixel;
         s1_col_ff   <= c0;
         s1_row_ff   <= r0;
         s1_mode_ff  <= frame_mode_in;
         fwd_data_ff <= line_wr_data;
      end
   end

   blm_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (LINE_W)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (req_acc),
      .rd_addr (c0),
      .rd_data (ram_rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr_data)
   );

   always_comb begin
      line_data    = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
      pp           = line_data[LINE_W-1:RGB_W];
      pv           = line_data[RGB_W-1:0];
      rgb          = s1_pix_ff[RGB_W-1:0];
      line_wr_data = {pv, rgb};
      row_is_last  = (s1_row_ff == hlast_ff);
      col_is_last  = (s1_col_ff == wlast_ff);
   end

   always_comb begin
      blm_rsp_type copy_b, blend_b;
      copy_b.pixel = s1_pix_ff;
      copy_b.row   = POS_W'(s1_row_ff);
      copy_b.col   = POS_W'(s1_col_ff);
      copy_b.last  = 1'b1;
      copy_b.done  = row_is_last && col_is_last;
      blend_b      = copy_b;
      blend_b.row  = POS_W'(s1_row_ff - RW'(1));
      blend_b.done = 1'b0;
      blend_b.pixel = {8'h00, smooth3(pp, pv, rgb)};
      slot0 = copy_b;
      slot1 = copy_b;
      v0    = 1'b0;
      v1    = 1'b0;
      case (s1_mode_ff)
         MODE_SMOOTH: begin
            if (s1_row_ff >= RW'(2)) begin
               slot0 = blend_b;
               v0    = 1'b1;
               v1    = row_is_last;
            end else if (s1_row_ff == '0 || row_is_last) begin
               v0 = 1'b1;
            end
         end
         MODE_UP: begin
            v0 = 1'b1;
            if (s1_row_ff != '0) begin
               slot0.pixel = {8'h00, quarter(pv, rgb)};
            end
         end
         MODE_DOWN: begin
            if (s1_row_ff != '0) begin
               slot0       = blend_b;
               slot0.pixel = {8'h00, quarter(rgb, pv)};
               v0          = 1'b1;
               v1          = row_is_last;
            end else if (row_is_last) begin
               v0 = 1'b1;
            end
         end
         default: begin
            v0 = 1'b1;
         end
      endcase
      slot0.last = !v1;
   end

   blm_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (s1_fire && v0),
      .push1      (s1_fire && v1),
      .push0_data (slot0),
      .push1_data (slot1),
      .room       (fifo_room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

   assign rsp_out_pixel   = rsp_data.pixel;
   assign rsp_out_row     = rsp_data.row;
   assign rsp_out_col     = rsp_data.col;
   assign rsp_last_of_run = rsp_data.last;
   assign rsp_frame_done  = rsp_data.done;

   `BLM_ASSERT_NXT(a_accept_loads, clock, reset, req_acc, s1_valid_ff)
   `BLM_ASSERT_IMP(a_slot_order, clock, reset, s1_valid_ff && v1, v0)
   `BLM_ASSERT_IMP(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done,
                   rsp_last_of_run)

endmodule
